### sv/dft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMX frame transmitter package
// Shared constants, codes and types of the DMX frame transmitter.
// ----------------------------------------------------------------------------
package dft_pkg;

   // Number of DMX channels held in each level store.
   localparam int CHANNELS = 512;
   localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CHANNELS - 1);

   localparam int LEVEL_W = 8;
   localparam int CHAN_W  = 9;
   localparam int DIV_W   = 12;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W = 1;

   // Input item kinds.
   localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPLY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

   // Slot kinds reported with each result.
   localparam logic [1:0] SLOT_BREAK = 2'd0;
   localparam logic [1:0] SLOT_START = 2'd1;
   localparam logic [1:0] SLOT_DATA  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_DIV = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_DIV  = 1'd1;

   localparam logic [DIV_W-1:0] NORMAL_DIV_RESET = 12'd3;
   localparam logic [DIV_W-1:0] BREAK_DIV_RESET  = 12'd19;

   typedef enum logic [1:0] {
      PH_BREAK,
      PH_START,
      PH_DATA
   } phase_type;

   typedef enum logic [1:0] {
      SW_CLEAR,
      SW_IDLE,
      SW_COPY
   } sweep_state_type;

   // Memory control produced by the sweep engine.
   typedef struct packed {
      logic              busy;
      logic              clear;
      logic              stg_rd;
      logic [ADDR_W-1:0] stg_addr;
      logic              live_we;
      logic [ADDR_W-1:0] live_addr;
   } sweep_ctl_type;

endpackage
`default_nettype wire

### sv/dft_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMX frame transmitter RAM
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module dft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
   input  wire logic [WIDTH-1:0]                 wdata,
   output logic      [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### sv/dft_sweep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMX frame transmitter sweep engine
// Clears both stores after reset and copies staged levels into the live store.
// ----------------------------------------------------------------------------
module dft_sweep (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start_copy,
   output dft_pkg::sweep_ctl_type     ctl
);

   dft_pkg::sweep_state_type state_ff, state_in;
   logic [dft_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [dft_pkg::ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic                       wr_pend_ff, wr_pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dft_pkg::SW_CLEAR;
         addr_ff    <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         wr_pend_ff <= wr_pend_in;
      end
      wr_addr_ff <= wr_addr_in;
   end

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = addr_ff;
      ctl        = '0;
      unique case (state_ff)
         dft_pkg::SW_CLEAR: begin
            ctl.clear     = 1'b1;
            ctl.stg_addr  = addr_ff;
            ctl.live_we   = 1'b1;
            ctl.live_addr = addr_ff;
            if (addr_ff == dft_pkg::LAST_ADDR) begin
               addr_in  = '0;
               state_in = dft_pkg::SW_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         dft_pkg::SW_COPY: begin
            // Read one staged entry; its data is written to the live store in the next cycle.
            ctl.stg_rd   = 1'b1;
            ctl.stg_addr = addr_ff;
            wr_pend_in   = 1'b1;
            if (addr_ff == dft_pkg::LAST_ADDR) begin
               addr_in  = '0;
               state_in = dft_pkg::SW_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         default: begin
            if (start_copy) begin
               state_in = dft_pkg::SW_COPY;
            end
         end
      endcase
      if (wr_pend_ff) begin
         ctl.live_we   = 1'b1;
         ctl.live_addr = wr_addr_ff;
      end
      ctl.busy = (state_ff != dft_pkg::SW_IDLE) || wr_pend_ff;
   end

endmodule
`default_nettype wire

### sv/dmx_frame_transmitter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMX frame transmitter unit
// Sequences DMX512 frames from a staged and a live channel level store.
// ----------------------------------------------------------------------------
// The block holds two single-port level stores of CHANNELS bytes each. A set
// beat writes one staged level; a set to a channel beyond the store is accepted
// and dropped. An apply beat copies the whole staged store into the live store,
// one entry a cycle, and the block stalls its input until the copy is done. A
// tick beat produces the next slot of the frame: break and start-code slots come
// straight from the sequencer, while a data slot reads the live store and is
// completed once the registered read of that store returns. Kind 3 is accepted
// and ignored. After reset a clearing pass writes zero to every entry of both
// stores, one entry a cycle, during which no input beat is accepted;
// configuration writes are taken at any time. Each result sits in an output
// register, so set and apply beats are still taken while a slot waits to be
// collected; a tick also waits while that register is full and stalled. The
// divisors reported are those held when the tick is accepted.
// ----------------------------------------------------------------------------
module dmx_frame_transmitter_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Configuration
   input  wire logic                                csr_we,
   input  wire logic [dft_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [dft_pkg::DIV_W-1:0]           csr_wdata,
   // Input items
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [dft_pkg::KIND_W-1:0]          req_kind,
   input  wire logic [dft_pkg::CHAN_W-1:0]          req_channel,
   input  wire logic [dft_pkg::LEVEL_W-1:0]         req_value,
   // Result slots
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [dft_pkg::LEVEL_W-1:0]         rsp_tx_byte,
   output logic      [dft_pkg::DIV_W-1:0]           rsp_baud_divisor,
   output logic      [1:0]                          rsp_slot_kind,
   output logic      [dft_pkg::CHAN_W-1:0]          rsp_slot_index
);

   // Configuration registers.
   logic [dft_pkg::DIV_W-1:0] normal_div_ff, break_div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_div_ff <= dft_pkg::NORMAL_DIV_RESET;
         break_div_ff  <= dft_pkg::BREAK_DIV_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            dft_pkg::CSR_NORMAL_DIV: normal_div_ff <= csr_wdata;
            dft_pkg::CSR_BREAK_DIV:  break_div_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sweep engine for the reset clear and the apply copy.
   dft_pkg::sweep_ctl_type sweep;
   logic                   start_copy;

   dft_sweep u_sweep (
      .clock      (clock),
      .reset      (reset),
      .start_copy (start_copy),
      .ctl        (sweep)
   );

   // Frame sequencer state.
   dft_pkg::phase_type         phase_ff, phase_in;
   logic [dft_pkg::ADDR_W-1:0] slot_ff, slot_in;
   logic                       data_rd_ff, data_rd_in;
   logic [dft_pkg::ADDR_W-1:0] data_idx_ff, data_idx_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [dft_pkg::LEVEL_W-1:0]  tx_byte_ff, tx_byte_in;
   logic [dft_pkg::DIV_W-1:0]    baud_div_ff, baud_div_in;
   logic [1:0]                   slot_kind_ff, slot_kind_in;
   logic [dft_pkg::CHAN_W-1:0]   slot_index_ff, slot_index_in;

   // Store ports.
   logic                          stg_we, live_we;
   logic [dft_pkg::ADDR_W-1:0]    stg_addr, live_addr;
   logic [dft_pkg::LEVEL_W-1:0]   stg_wdata, live_wdata, stg_rdata, live_rdata;

   logic busy;
   logic req_accept;
   logic set_hit;
   logic tick_accept;

   dft_ram #(.WIDTH(dft_pkg::LEVEL_W), .DEPTH(dft_pkg::CHANNELS)) u_staged (
      .clock (clock),
      .we    (stg_we),
      .addr  (stg_addr),
      .wdata (stg_wdata),
      .rdata (stg_rdata)
   );

   dft_ram #(.WIDTH(dft_pkg::LEVEL_W), .DEPTH(dft_pkg::CHANNELS)) u_live (
      .clock (clock),
      .we    (live_we),
      .addr  (live_addr),
      .wdata (live_wdata),
      .rdata (live_rdata)
   );

   // A data slot in flight holds the input off for its read cycle; a tick
   // additionally needs room in the output register.
   assign busy      = sweep.busy || data_rd_ff;
   assign req_stall = busy ||
                      ((req_kind == dft_pkg::KIND_TICK) && rsp_valid_ff && rsp_stall);
   assign req_accept  = req_valid && !req_stall;
   assign set_hit     = req_accept && (req_kind == dft_pkg::KIND_SET) &&
                        ({1'b0, req_channel} < (dft_pkg::CHAN_W + 1)'(dft_pkg::CHANNELS));
   assign start_copy  = req_accept && (req_kind == dft_pkg::KIND_APPLY);
   assign tick_accept = req_accept && (req_kind == dft_pkg::KIND_TICK);

   // The staged store is written by set beats and the clear, read by the copy.
   always_comb begin
      stg_we    = sweep.clear || set_hit;
      stg_wdata = sweep.clear ? '0 : req_value;
      if (sweep.clear || sweep.stg_rd) begin
         stg_addr = sweep.stg_addr;
      end else begin
         stg_addr = req_channel[dft_pkg::ADDR_W-1:0];
      end
   end

   // The live store is written by the clear and the copy, read by data ticks.
   always_comb begin
      live_we    = sweep.live_we;
      live_wdata = sweep.clear ? '0 : stg_rdata;
      live_addr  = sweep.live_we ? sweep.live_addr : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dft_pkg::PH_BREAK;
         slot_ff      <= '0;
         data_rd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         slot_ff      <= slot_in;
         data_rd_ff   <= data_rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      data_idx_ff   <= data_idx_in;
      tx_byte_ff    <= tx_byte_in;
      baud_div_ff   <= baud_div_in;
      slot_kind_ff  <= slot_kind_in;
      slot_index_ff <= slot_index_in;
   end

   always_comb begin
      phase_in      = phase_ff;
      slot_in       = slot_ff;
      data_rd_in    = 1'b0;
      data_idx_in   = data_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      tx_byte_in    = tx_byte_ff;
      baud_div_in   = baud_div_ff;
      slot_kind_in  = slot_kind_ff;
      slot_index_in = slot_index_ff;

      if (data_rd_ff) begin
         // Live level has arrived: complete the data slot. The divisor was
         // captured when the tick was taken.
         rsp_valid_in  = 1'b1;
         tx_byte_in    = live_rdata;
         slot_kind_in  = dft_pkg::SLOT_DATA;
         slot_index_in = dft_pkg::CHAN_W'(data_idx_ff);
      end else if (tick_accept) begin
         unique case (phase_ff)
            dft_pkg::PH_START: begin
               rsp_valid_in  = 1'b1;
               tx_byte_in    = '0;
               baud_div_in   = normal_div_ff;
               slot_kind_in  = dft_pkg::SLOT_START;
               slot_index_in = '0;
               phase_in      = dft_pkg::PH_DATA;
            end
            dft_pkg::PH_DATA: begin
               // The live store is addressed by the slot counter this cycle.
               // The output register is empty next cycle, so the divisor can
               // be latched into it now.
               data_rd_in  = 1'b1;
               data_idx_in = slot_ff;
               baud_div_in = normal_div_ff;
               if (slot_ff == dft_pkg::LAST_ADDR) begin
                  slot_in  = '0;
                  phase_in = dft_pkg::PH_BREAK;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
            default: begin
               rsp_valid_in  = 1'b1;
               tx_byte_in    = '0;
               baud_div_in   = break_div_ff;
               slot_kind_in  = dft_pkg::SLOT_BREAK;
               slot_index_in = '0;
               phase_in      = dft_pkg::PH_START;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tx_byte      = tx_byte_ff;
   assign rsp_baud_divisor = baud_div_ff;
   assign rsp_slot_kind    = slot_kind_ff;
   assign rsp_slot_index   = slot_index_ff;

endmodule
`default_nettype wire
